FILE: hdl/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants of the turnout motor controller.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int unsigned TIMER_W     = 8;
    localparam int unsigned PRESCALE_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [TIMER_W-1:0]    POWER_HOLD_RESET        = 8'd16;
    localparam logic [PRESCALE_W-1:0] TICKS_PER_QUARTER_RESET = 8'd25;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POWER_HOLD_QUARTERS = 2'd0,
        CFG_TICKS_PER_QUARTER   = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic drive_normal;
        logic motor_power;
        logic lamp_normal;
        logic lamp_reverse;
    } result_t;

    typedef struct packed {
        logic level;
        logic press;
    } key_status_t;

endpackage

FILE: hdl/tmc_debounce.sv
// ----------------------------------------------------------------------------
// tmc_debounce
// Two-bit vertical counter key debounce with press detection, one step per item.
// ----------------------------------------------------------------------------
module tmc_debounce (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                key_raw,
    output tmc_pkg::key_status_t status
);
    import tmc_pkg::*;

    logic level_reg;
    logic low_reg;
    logic high_reg;
    logic level_next;
    logic low_next;
    logic high_next;
    logic diff;
    logic toggle;

    always_comb
    begin
        diff       = level_reg ^ key_raw;
        low_next   = ~(low_reg & diff);
        high_next  = low_next ^ (high_reg & diff);
        toggle     = diff & low_next & high_next;
        level_next = level_reg ^ toggle;
    end

    assign status.level = level_next;
    assign status.press = level_next & toggle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            low_reg   <= 1'b0;
            high_reg  <= 1'b0;
        end
        else if (step)
        begin
            level_reg <= level_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

endmodule

FILE: hdl/turnout_motor_controller_unit.sv
// ----------------------------------------------------------------------------
// turnout_motor_controller_unit
// Per-tick turnout motor control: key debounce, position request, power timer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_ready   | key_raw manual_mode remote_reverse
//          |           |                       | sense_normal sense_reverse
//  out     | from      | out_valid / out_ready | drive_normal motor_power
//          |           |                       | lamp_normal lamp_reverse
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index cfg_data
//
//  one item per cycle while in_ready is high
//  state advances on the accepting edge, result goes to an output register
//  a skid register takes one more result while out is stalled
//  in_ready drops only while the skid register is full
//  rst_n clears all state; hold 16 quarters, 25 ticks per quarter
// ----------------------------------------------------------------------------
module turnout_motor_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               key_raw,
    input  logic                               manual_mode,
    input  logic                               remote_reverse,
    input  logic                               sense_normal,
    input  logic                               sense_reverse,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               drive_normal,
    output logic                               motor_power,
    output logic                               lamp_normal,
    output logic                               lamp_reverse,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmc_pkg::*;

    logic [TIMER_W-1:0]    hold_reg;
    logic [PRESCALE_W-1:0] tpq_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [PRESCALE_W-1:0] prescale_next;
    logic [PRESCALE_W-1:0] prescale_inc;
    logic                  request_reg;
    logic                  request_next;
    logic [TIMER_W-1:0]    timer_reg;
    logic [TIMER_W-1:0]    timer_next;
    logic [TIMER_W-1:0]    timer_loaded;
    logic                  quarter;
    logic                  mismatch;
    logic                  accept;
    logic                  out_take;
    key_status_t           key_status;
    result_t               result_next;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    assign accept   = in_valid & in_ready;
    assign out_take = out_valid_reg & out_ready;
    assign in_ready = ~skid_valid_reg;
    assign cfg_ready = 1'b1;

    tmc_debounce u_debounce (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .key_raw (key_raw),
        .status  (key_status)
    );

    always_comb
    begin
        prescale_inc = prescale_reg + 8'd1;
        quarter      = (prescale_inc >= tpq_reg);
        prescale_next = quarter ? '0 : prescale_inc;

        if (manual_mode)
            request_next = request_reg ^ key_status.press;
        else
            request_next = remote_reverse;

        mismatch     = (sense_normal != ~request_next) || (sense_reverse != request_next);
        timer_loaded = mismatch ? hold_reg : timer_reg;

        result_next.drive_normal = ~request_next;
        result_next.motor_power  = (timer_loaded != '0);
        result_next.lamp_normal  = ~request_next;
        result_next.lamp_reverse = request_next;

        if (quarter && (timer_loaded != '0))
            timer_next = timer_loaded - 8'd1;
        else
            timer_next = timer_loaded;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= POWER_HOLD_RESET;
            tpq_reg  <= TICKS_PER_QUARTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_POWER_HOLD_QUARTERS: hold_reg <= cfg_data;
                CFG_TICKS_PER_QUARTER:   tpq_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            request_reg  <= 1'b0;
            timer_reg    <= '0;
        end
        else if (accept)
        begin
            prescale_reg <= prescale_next;
            request_reg  <= request_next;
            timer_reg    <= timer_next;
        end
    end

    // output and skid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
                skid_reg <= result_next;
            else
                out_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_normal = out_reg.drive_normal;
    assign motor_power  = out_reg.motor_power;
    assign lamp_normal  = out_reg.lamp_normal;
    assign lamp_reverse = out_reg.lamp_reverse;

endmodule

FILE: hdl/tmc_checker.sv
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the turnout motor controller, bound to the top level.
// ----------------------------------------------------------------------------
module tmc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic drive_normal,
    input logic lamp_normal,
    input logic lamp_reverse
);

    // lamps are one-hot
    a_lamps_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lamp_normal != lamp_reverse))
        else $error("lamps not one-hot");

    // drive follows the normal lamp
    a_drive_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_normal == lamp_normal))
        else $error("drive direction disagrees with lamp");

    // input stalls only behind a pending result
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // out_valid is high in the cycle after an item is accepted
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item produced no result");

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind turnout_motor_controller_unit tmc_checker u_tmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_normal (drive_normal),
    .lamp_normal  (lamp_normal),
    .lamp_reverse (lamp_reverse)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the turnout motor controller. A queue of pending
// ticks, register writes and drain points feeds a falling-edge driver; a
// rising-edge monitor predicts each tick's outputs and compares every result
// item against the oldest prediction. Directed ticks cover debounce at reset,
// presses in both modes and every sensor pair; random segments hold key
// levels for runs and mostly keep the sensors in line with the request so the
// power timer runs out, under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

    import tmc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int NUM_BLOCKS  = 13;

    typedef enum {OP_TICK, OP_WRITE, OP_DRAIN} tick_op_t;

    typedef struct {
        tick_op_t   op;
        logic       key;
        logic       manual;
        logic       remote;
        logic       sn;
        logic       sr;
        logic       track;
        cfg_index_t idx;
        logic [7:0] data;
    } tick_entry_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic       key_raw        = 1'b0;
    logic       manual_mode    = 1'b0;
    logic       remote_reverse = 1'b0;
    logic       sense_normal   = 1'b0;
    logic       sense_reverse  = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic       drive_normal;
    logic       motor_power;
    logic       lamp_normal;
    logic       lamp_reverse;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    tick_entry_t tick_q[$];
    result_t     motor_out_q[$];

    int send_idle_pct  = 22;
    int recv_stall_pct = 51;
    int fail_count     = 0;
    int stall_cycles   = 0;

    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // predicted controller state
    logic       key_level  = 1'b0;
    logic       vc_lo      = 1'b0;
    logic       vc_hi      = 1'b0;
    logic [7:0] prescale   = '0;
    logic       req_rev    = 1'b0;
    logic [7:0] power_cnt  = '0;
    logic [7:0] hold_cfg   = POWER_HOLD_RESET;
    logic [7:0] tpq_cfg    = TICKS_PER_QUARTER_RESET;

    turnout_motor_controller_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key_raw        (key_raw),
        .manual_mode    (manual_mode),
        .remote_reverse (remote_reverse),
        .sense_normal   (sense_normal),
        .sense_reverse  (sense_reverse),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_normal   (drive_normal),
        .motor_power    (motor_power),
        .lamp_normal    (lamp_normal),
        .lamp_reverse   (lamp_reverse),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_fail(input string msg);
        fail_count++;
        if (fail_count <= 100)
            $display("%0.1f ns mismatch: %s", $realtime, msg);
    endtask

    task automatic turnout_tick(input logic key, input logic manual, input logic remote,
                                input logic sn, input logic sr, output result_t res);
        logic diff;
        logic press;
        logic quarter;
        diff      = key_level ^ key;
        vc_lo     = ~(vc_lo & diff);
        vc_hi     = vc_lo ^ (vc_hi & diff);
        diff      = diff & vc_lo & vc_hi;
        key_level = key_level ^ diff;
        press     = key_level & diff;

        quarter  = 1'b0;
        prescale = prescale + 8'd1;
        if (prescale >= tpq_cfg)
        begin
            prescale = '0;
            quarter  = 1'b1;
        end

        if (manual)
        begin
            if (press)
                req_rev = ~req_rev;
        end
        else
            req_rev = remote;

        if (sn != ~req_rev || sr != req_rev)
            power_cnt = hold_cfg;

        res.drive_normal = ~req_rev;
        res.motor_power  = (power_cnt != 0);
        res.lamp_normal  = ~req_rev;
        res.lamp_reverse = req_rev;

        if (quarter && power_cnt != 0)
            power_cnt = power_cnt - 8'd1;
    endtask

    task automatic add_tick(input logic key, input logic manual, input logic remote,
                            input logic sn, input logic sr, input logic track);
        tick_entry_t e;
        e.op     = OP_TICK;
        e.key    = key;
        e.manual = manual;
        e.remote = remote;
        e.sn     = sn;
        e.sr     = sr;
        e.track  = track;
        e.idx    = CFG_POWER_HOLD_QUARTERS;
        e.data   = '0;
        tick_q.push_back(e);
    endtask

    task automatic add_write(input cfg_index_t idx, input logic [7:0] data);
        tick_entry_t e;
        e.op     = OP_WRITE;
        e.key    = 1'b0;
        e.manual = 1'b0;
        e.remote = 1'b0;
        e.sn     = 1'b0;
        e.sr     = 1'b0;
        e.track  = 1'b0;
        e.idx    = idx;
        e.data   = data;
        tick_q.push_back(e);
    endtask

    task automatic add_drain();
        tick_entry_t e;
        e.op     = OP_DRAIN;
        e.key    = 1'b0;
        e.manual = 1'b0;
        e.remote = 1'b0;
        e.sn     = 1'b0;
        e.sr     = 1'b0;
        e.track  = 1'b0;
        e.idx    = CFG_POWER_HOLD_QUARTERS;
        e.data   = '0;
        tick_q.push_back(e);
    endtask

    // segments of held key levels, mostly with sensors following the request
    task automatic queue_random_ticks(input int n);
        int   left;
        int   seg;
        int   run;
        logic man;
        logic rem;
        logic lvl;
        logic trk;
        left = n;
        run  = 0;
        lvl  = 1'($urandom_range(1));
        while (left > 0)
        begin
            seg = $urandom_range(4, 40);
            if (seg > left)
                seg = left;
            man = 1'($urandom_range(1));
            rem = 1'($urandom_range(1));
            trk = ($urandom_range(9) < 7);
            repeat (seg)
            begin
                if (run == 0)
                begin
                    lvl = ~lvl;
                    run = $urandom_range(1, 9);
                end
                run--;
                if ($urandom_range(15) == 0)
                    rem = ~rem;
                add_tick(($urandom_range(19) == 0) ? ~lvl : lvl, man, rem,
                         1'($urandom_range(1)), 1'($urandom_range(1)), trk);
            end
            left -= seg;
        end
    endtask

    task automatic wait_idle();
        while (tick_q.size() != 0 || in_valid || cfg_valid || motor_out_q.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        logic        nxt_valid;
        logic        nxt_cfg;
        tick_entry_t e;
        nxt_valid = in_valid && !in_taken;
        nxt_cfg   = cfg_valid && !cfg_taken;
        if (rst_n && !nxt_valid && !nxt_cfg && tick_q.size() != 0)
        begin
            e = tick_q[0];
            case (e.op)
                OP_TICK:
                    if ($urandom_range(99) >= send_idle_pct)
                    begin
                        void'(tick_q.pop_front());
                        key_raw        <= e.key;
                        manual_mode    <= e.manual;
                        remote_reverse <= e.remote;
                        if (e.track)
                        begin
                            sense_normal  <= ~req_rev;
                            sense_reverse <= req_rev;
                        end
                        else
                        begin
                            sense_normal  <= e.sn;
                            sense_reverse <= e.sr;
                        end
                        nxt_valid = 1'b1;
                    end
                OP_WRITE:
                    if (motor_out_q.size() == 0)
                    begin
                        void'(tick_q.pop_front());
                        cfg_index <= e.idx;
                        cfg_data  <= e.data;
                        nxt_cfg = 1'b1;
                    end
                default:
                    if (motor_out_q.size() == 0)
                        void'(tick_q.pop_front());
            endcase
        end
        in_valid  <= nxt_valid;
        cfg_valid <= nxt_cfg;
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        string   names[4];
        names     = '{"drive_normal", "motor_power", "lamp_normal", "lamp_reverse"};
        in_taken  = in_valid && in_ready;
        cfg_taken = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {drive_normal, motor_power, lamp_normal, lamp_reverse};
                if (motor_out_q.size() == 0)
                    report_fail("result item with no tick waiting");
                else
                begin
                    want = motor_out_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[3-i] !== want[3-i])
                            report_fail($sformatf("%s got %b expected %b",
                                                  names[i], got[3-i], want[3-i]));
                end
            end
            if (cfg_taken)
            begin
                if (cfg_index == CFG_POWER_HOLD_QUARTERS)
                    hold_cfg = cfg_data;
                else if (cfg_index == CFG_TICKS_PER_QUARTER)
                    tpq_cfg = cfg_data;
            end
            if (in_taken)
            begin
                turnout_tick(key_raw, manual_mode, remote_reverse,
                             sense_normal, sense_reverse, want);
                motor_out_q.push_back(want);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int hold_set[NUM_BLOCKS];
        int tpq_set[NUM_BLOCKS];
        hold_set = '{16, 0, 255, 1, 255, -1, -1, -1, 0, -1, -1, -1, 1};
        tpq_set  = '{25, 0, 255, 1, 0, -1, -1, -1, 255, -1, -1, -1, 1};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // press on the first tick after reset, counter still clear
        add_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        repeat (4) add_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        // press in remote mode is dropped
        repeat (4) add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        repeat (4) add_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        // manual press toggles back to normal
        repeat (4) add_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);

        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            if (b == 5 || b == 9)
            begin
                wait_idle();
                send_idle_pct  = (b == 5) ? 51 : 0;
                recv_stall_pct = (b == 5) ? 22 : 0;
            end
            if (b > 0)
            begin
                add_write(CFG_POWER_HOLD_QUARTERS,
                          (hold_set[b] < 0) ? 8'($urandom_range(6)) : 8'(hold_set[b]));
                add_write(CFG_TICKS_PER_QUARTER,
                          (tpq_set[b] < 0) ? 8'($urandom_range(4)) : 8'(tpq_set[b]));
            end
            queue_random_ticks(70);
            add_drain();
            queue_random_ticks(80);
            while (tick_q.size() != 0)
                @(posedge clk);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tmc_pkg.sv
hdl/tmc_debounce.sv
hdl/turnout_motor_controller_unit.sv
hdl/tmc_checker.sv
tb/tb_top.sv
